>>> rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// Partial shuffle sampler package
// Shared constants, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pss_pkg;

   // Default sizing of the sampler.
   localparam int MAX_DATASET_DEF = 1024;
   localparam int RANDOM_BITS_DEF = 32;

   // Fixed widths of the stream and configuration fields.
   localparam int REQ_TDATA_W = 32;
   localparam int SAMPLE_W    = 10;
   localparam int RSP_TDATA_W = 16;
   localparam int CFG_W       = 11;
   localparam int CSR_INDEX_W = 8;

   // Width of the batch tag stored with every table entry.
   localparam int EPOCH_W = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_DATASET_SIZE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_BATCH_LEN    = CSR_INDEX_W'(1);

   // Register reset values.
   localparam logic [CFG_W-1:0] DATASET_SIZE_RST = CFG_W'(1024);
   localparam logic [CFG_W-1:0] BATCH_LEN_RST    = CFG_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADDR,
      ST_SWAP,
      ST_WRJ,
      ST_ERR
   } pss_state_type;

   typedef struct packed {
      logic load_in;   // capture the random fraction
      logic mul;       // register the partial products
      logic rd;        // form the swap address and read both entries
      logic wr_pos;    // write the entry at the batch position
      logic wr_j;      // write the entry at the swap address
      logic emit_ok;   // load a sample result and advance the batch
      logic emit_err;  // load an error result and restart the batch
   } pss_cmd_type;

   typedef struct packed {
      logic clearing;  // table clearing pass in progress
      logic size_err;  // sizes invalid for the next draw
      logic out_free;  // output register can take a result this cycle
   } pss_status_type;

endpackage

>>> rtl/pss_ctrl.sv
// ----------------------------------------------------------------------------
// Partial shuffle sampler controller
// Sequences one draw: multiply, address and read, swap, write back, emit, or emits an error result for invalid sizes.
// ----------------------------------------------------------------------------
module pss_ctrl
   import pss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  pss_status_type status,
   output pss_cmd_type    cmd
);

   pss_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !status.clearing) begin
               state_in = status.size_err ? ST_ERR : ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ADDR;
         ST_ADDR: state_in = ST_SWAP;
         ST_SWAP: state_in = ST_WRJ;
         ST_WRJ: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = !status.clearing;
            cmd.load_in = req_tvalid && !status.clearing;
         end
         ST_MUL:  cmd.mul = 1'b1;
         ST_ADDR: cmd.rd = 1'b1;
         ST_SWAP: cmd.wr_pos = 1'b1;
         ST_WRJ: begin
            cmd.wr_j    = 1'b1;
            cmd.emit_ok = status.out_free;
         end
         ST_ERR:  cmd.emit_err = status.out_free;
         default: begin
            req_tready = 1'b0;
            cmd        = '0;
         end
      endcase
   end

endmodule

>>> rtl/pss_datapath.sv
// ----------------------------------------------------------------------------
// Partial shuffle sampler datapath
// Configuration registers, scaling multiplier, tagged index table with its
// clearing pass, batch position and the output register.
// ----------------------------------------------------------------------------
module pss_datapath
   import pss_pkg::*;
#(
   parameter int MAX_DATASET = MAX_DATASET_DEF,
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   input  pss_cmd_type            cmd,
   output pss_status_type         status,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [SAMPLE_W-1:0]    rsp_index,
   output logic                   rsp_last,
   output logic                   rsp_error
);

   localparam int AW      = $clog2(MAX_DATASET);
   localparam int SW      = $clog2(MAX_DATASET + 1);
   localparam int CW      = (SW > CFG_W) ? SW : CFG_W;
   localparam int H       = (RANDOM_BITS + 1) / 2;
   localparam int HB      = RANDOM_BITS - H;
   localparam int SUMW    = RANDOM_BITS + SW + 1;
   localparam int ENTRY_W = EPOCH_W + AW;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
   localparam logic [AW-1:0]      CLEAR_END   = AW'(MAX_DATASET - 1);

   logic [CFG_W-1:0]       dataset_size_ff;
   logic [CFG_W-1:0]       batch_len_ff;
   logic [RANDOM_BITS-1:0] rand_ff;
   logic [H+SW-1:0]        prod_lo_ff;
   logic [HB+SW-1:0]       prod_hi_ff;
   logic [AW-1:0]          pos_ff;
   logic [AW-1:0]          j_ff;
   logic [AW-1:0]          vi_ff;
   logic [AW-1:0]          vj_ff;
   logic [EPOCH_W-1:0]     epoch_ff;
   logic                   clearing_ff;
   logic [AW-1:0]          clear_cnt_ff;
   logic [ENTRY_W-1:0]     rd_a_ff;
   logic [ENTRY_W-1:0]     rd_b_ff;
   logic                   out_valid_ff;
   logic [SAMPLE_W-1:0]    out_index_ff;
   logic                   out_last_ff;
   logic                   out_error_ff;

   logic [ENTRY_W-1:0]     table_mem [MAX_DATASET];

   logic [CW-1:0]          size_wide;
   logic [SW-1:0]          size_eff;
   logic [SW-1:0]          remaining;
   logic [SUMW-1:0]        scaled_sum;
   logic [SW-1:0]          offset;
   logic [SW-1:0]          j_sum;
   logic [SW-1:0]          j_clamp;
   logic [AW-1:0]          j_addr;
   logic [AW-1:0]          vi_now;
   logic [AW-1:0]          vj_now;
   logic                   last;
   logic                   cfg_hit;
   logic                   restart;
   logic                   out_free;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [ENTRY_W-1:0]     wr_data;

   // Effective dataset size and the count of entries still in play.
   assign size_wide = (CW'(dataset_size_ff) > CW'(MAX_DATASET)) ? CW'(MAX_DATASET)
                                                               : CW'(dataset_size_ff);
   assign size_eff  = SW'(size_wide);
   assign remaining = size_eff - SW'(pos_ff);

   // floor(r * n / 2^RANDOM_BITS) from the two registered partial products.
   assign scaled_sum = (SUMW'(prod_hi_ff) << H) + SUMW'(prod_lo_ff);
   assign offset     = SW'(scaled_sum >> RANDOM_BITS);
   assign j_sum      = SW'(pos_ff) + offset;
   assign j_clamp    = (j_sum >= size_eff) ? (size_eff - SW'(1)) : j_sum;
   assign j_addr     = j_clamp[AW-1:0];

   // An entry whose tag is not the current batch reads as its own index.
   assign vi_now = (rd_a_ff[ENTRY_W-1:AW] == epoch_ff) ? rd_a_ff[AW-1:0] : pos_ff;
   assign vj_now = (rd_b_ff[ENTRY_W-1:AW] == epoch_ff) ? rd_b_ff[AW-1:0] : j_ff;

   assign last     = (CW'(pos_ff) + CW'(1)) == CW'(batch_len_ff);
   assign cfg_hit  = csr_valid && (csr_index == REG_DATASET_SIZE ||
                                   csr_index == REG_BATCH_LEN);
   assign restart  = cfg_hit || cmd.emit_err || (cmd.emit_ok && last);
   assign out_free = !out_valid_ff || rsp_tready;

   assign status.clearing = clearing_ff;
   assign status.size_err = (batch_len_ff == '0) ||
                            (CW'(batch_len_ff) > size_wide) ||
                            (CW'(pos_ff) >= CW'(batch_len_ff));
   assign status.out_free = out_free;

   // Single write port, shared by the clearing pass and the two swap writes.
   assign wr_en   = clearing_ff || cmd.wr_pos || cmd.wr_j;
   assign wr_addr = clearing_ff ? clear_cnt_ff : (cmd.wr_pos ? pos_ff : j_ff);
   assign wr_data = clearing_ff ? '0 : {epoch_ff, (cmd.wr_pos ? vj_now : vi_ff)};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_a_ff <= table_mem[pos_ff];
         rd_b_ff <= table_mem[j_addr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         rand_ff <= RANDOM_BITS'(req_tdata);
      end
      if (cmd.mul) begin
         prod_lo_ff <= (H+SW)'(rand_ff[H-1:0]) * (H+SW)'(remaining);
         prod_hi_ff <= (HB+SW)'(rand_ff[RANDOM_BITS-1:H]) * (HB+SW)'(remaining);
      end
      if (cmd.rd) begin
         j_ff <= j_addr;
      end
      if (cmd.wr_pos) begin
         vi_ff <= vi_now;
         vj_ff <= vj_now;
      end
      if (cmd.emit_ok) begin
         out_index_ff <= SAMPLE_W'(vj_ff);
         out_last_ff  <= last;
         out_error_ff <= 1'b0;
      end else if (cmd.emit_err) begin
         out_index_ff <= '0;
         out_last_ff  <= 1'b0;
         out_error_ff <= 1'b1;
      end
   end

   // Control state: configuration, batch position, tag epoch, clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         dataset_size_ff <= DATASET_SIZE_RST;
         batch_len_ff    <= BATCH_LEN_RST;
         pos_ff          <= '0;
         epoch_ff        <= EPOCH_FIRST;
         clearing_ff     <= 1'b1;
         clear_cnt_ff    <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_index == REG_DATASET_SIZE) begin
            dataset_size_ff <= csr_data;
         end
         if (csr_valid && csr_index == REG_BATCH_LEN) begin
            batch_len_ff <= csr_data;
         end

         if (restart) begin
            pos_ff <= '0;
         end else if (cmd.emit_ok) begin
            pos_ff <= pos_ff + AW'(1);
         end

         if (clearing_ff) begin
            clear_cnt_ff <= clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == CLEAR_END) begin
               clearing_ff <= 1'b0;
            end
         end else if (restart) begin
            if (epoch_ff == EPOCH_LAST) begin
               epoch_ff     <= EPOCH_FIRST;
               clearing_ff  <= 1'b1;
               clear_cnt_ff <= '0;
            end else begin
               epoch_ff <= epoch_ff + EPOCH_W'(1);
            end
         end

         if (cmd.emit_ok || cmd.emit_err) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_index  = out_index_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_error  = out_error_ff;

endmodule

>>> rtl/partial_shuffle_sampler.sv
// ----------------------------------------------------------------------------
// Partial shuffle sampler
// Draws batches of distinct dataset indices by a partial Fisher-Yates shuffle.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one random fraction r/2^32 and
// produces exactly one transfer on the rsp_ channel: the dataset index drawn
// for the current batch position, with rsp_tlast on the final index of a
// batch. rsp_tuser flags a size error (a batch length of zero or one larger
// than the dataset), in which case the index is zero and the batch restarts.
// An item passes through the scaling multiply, a registered two-port read
// of the index table, and two writes through its single write port. The
// result is loaded into the output register with the second write, and the
// next item is accepted only after the block returns to idle. An error
// result is loaded from the error state, with no table access.
// The output register lets the next item run while a result waits; a stalled
// receiver holds the block only when a second result is ready to be loaded.
// Each table entry carries a batch tag, so a new batch starts without
// clearing the table. After reset, and once every 255 batch restarts, a
// clearing pass over all MAX_DATASET entries resets the tags; req_tready
// stays low during it while csr_ writes are still taken.
// Any csr_ write to a defined register restarts the batch. The sizes are
// to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module partial_shuffle_sampler
   import pss_pkg::*;
#(
   parameter int MAX_DATASET = MAX_DATASET_DEF,
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   // Input stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] random_fraction
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [9:0] sample_index, [15:10] zero
   output logic                   rsp_tlast,   // last_of_batch
   output logic                   rsp_tuser,   // [0] size_error
   // Configuration writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   pss_cmd_type         cmd;
   pss_status_type      status;
   logic [SAMPLE_W-1:0] rsp_index;

   // Register writes are always taken in the cycle they are offered.
   assign csr_ready = 1'b1;

   pss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pss_datapath #(
      .MAX_DATASET (MAX_DATASET),
      .RANDOM_BITS (RANDOM_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_tlast),
      .rsp_error  (rsp_tuser)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_index);

endmodule
